// File: hw/rtl/motion_adaptive_deinterlace_pixel_macros.svh
// Assertion helpers used by the deinterlacer core (madp_core).
`ifndef MOTION_ADAPTIVE_DEINTERLACE_PIXEL_MACROS_SVH
`define MOTION_ADAPTIVE_DEINTERLACE_PIXEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MADP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MADP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/madp_pkg.sv
`timescale 1ns / 1ps

package madp_pkg;

   localparam int PIXEL_BITS  = 16;
   localparam int PIX_W       = PIXEL_BITS;
   localparam int LANE_W      = 16;
   localparam int COEF_W      = 14;
   localparam int PEAK_W      = 16;
   localparam int COEF_SHIFT  = 13;
   localparam int HF_SHIFT    = 2;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_STAGES  = 4;

   // Difference terms need two extra bits: sign and one carry.
   localparam int DW          = PIX_W + 2;
   // A coefficient times a sum of up to four pixels.
   localparam int PROD_W      = COEF_W + PIX_W + 2;
   localparam int ACC_W       = PROD_W + 4;
   localparam int INT_W       = ACC_W - COEF_SHIFT;

   localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LF_NEAR   = 4'd0,
      REG_LF_FAR    = 4'd1,
      REG_HF_CENTER = 4'd2,
      REG_HF_TWO    = 4'd3,
      REG_HF_FOUR   = 4'd4,
      REG_SP_NEAR   = 4'd5,
      REG_SP_FAR    = 4'd6,
      REG_PEAK      = 4'd7
   } madp_reg_type;

   localparam logic [COEF_W-1:0] RST_LF_NEAR   = 14'd4309;
   localparam logic [COEF_W-1:0] RST_LF_FAR    = 14'd213;
   localparam logic [COEF_W-1:0] RST_HF_CENTER = 14'd5570;
   localparam logic [COEF_W-1:0] RST_HF_TWO    = 14'd3801;
   localparam logic [COEF_W-1:0] RST_HF_FOUR   = 14'd1016;
   localparam logic [COEF_W-1:0] RST_SP_NEAR   = 14'd5077;
   localparam logic [COEF_W-1:0] RST_SP_FAR    = 14'd981;
   localparam logic [PEAK_W-1:0] RST_PEAK      = 16'd65535;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic signed [DW-1:0] sdiff_type;
   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic        edge_mode;
      logic        spatial_check;
      logic        use_external;
      logic [15:0] prev2_center;
      logic [63:0] prev2_ring;
      logic [15:0] next2_center;
      logic [63:0] next2_ring;
      logic [31:0] prev_rows;
      logic [31:0] next_rows;
      logic [63:0] cur_rows;
      logic [15:0] external_pixel;
      logic        row_end_in;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] out_pixel;
      logic        row_end_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic [COEF_W-1:0] lf_near;
      logic [COEF_W-1:0] lf_far;
      logic [COEF_W-1:0] hf_center;
      logic [COEF_W-1:0] hf_two;
      logic [COEF_W-1:0] hf_four;
      logic [COEF_W-1:0] sp_near;
      logic [COEF_W-1:0] sp_far;
      logic [PEAK_W-1:0] peak;
   } coef_type;

endpackage

// File: hw/rtl/madp_if.sv
`timescale 1ns / 1ps

interface madp_req_if import madp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface madp_rsp_if import madp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface madp_csr_if import madp_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/madp_csr.sv
`timescale 1ns / 1ps

module madp_csr import madp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   madp_csr_if.sink     csr_chan,
   output coef_type     coef
);

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_chan.ready = 1'b1;
   assign coef = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_chan.valid) begin
         case (csr_chan.payload.index)
            REG_LF_NEAR:   coef_in.lf_near   = csr_chan.payload.data[COEF_W-1:0];
            REG_LF_FAR:    coef_in.lf_far    = csr_chan.payload.data[COEF_W-1:0];
            REG_HF_CENTER: coef_in.hf_center = csr_chan.payload.data[COEF_W-1:0];
            REG_HF_TWO:    coef_in.hf_two    = csr_chan.payload.data[COEF_W-1:0];
            REG_HF_FOUR:   coef_in.hf_four   = csr_chan.payload.data[COEF_W-1:0];
            REG_SP_NEAR:   coef_in.sp_near   = csr_chan.payload.data[COEF_W-1:0];
            REG_SP_FAR:    coef_in.sp_far    = csr_chan.payload.data[COEF_W-1:0];
            REG_PEAK:      coef_in.peak      = csr_chan.payload.data[PEAK_W-1:0];
            default: begin
               // Writes past the register list are dropped.
               coef_in = coef_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.lf_near   <= RST_LF_NEAR;
         coef_ff.lf_far    <= RST_LF_FAR;
         coef_ff.hf_center <= RST_HF_CENTER;
         coef_ff.hf_two    <= RST_HF_TWO;
         coef_ff.hf_four   <= RST_HF_FOUR;
         coef_ff.sp_near   <= RST_SP_NEAR;
         coef_ff.sp_far    <= RST_SP_FAR;
         coef_ff.peak      <= RST_PEAK;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// File: hw/rtl/madp_core.sv
`timescale 1ns / 1ps
`include "motion_adaptive_deinterlace_pixel_macros.svh"

module madp_core import madp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  coef_type     coef,
   madp_req_if.sink     req_chan,
   madp_rsp_if.source   rsp_chan
);

   typedef struct packed {
      pix_type   d;
      pix_type   td0;
      pix_type   td1;
      pix_type   td2;
      sdiff_type b;
      sdiff_type f;
      sdiff_type dme;
      sdiff_type dmc;
      pix_type   ce_avg;
      pix_type   xp;
      logic      sel_hf;
      logic      edge_mode;
      logic      spatial_check;
      logic      use_external;
      logic      row_end;
      prod_type  m_center;
      prod_type  m_two;
      prod_type  m_four;
      prod_type  m_lnear;
      prod_type  m_lfar;
      prod_type  m_snear;
      prod_type  m_sfar;
   } s1_type;

   typedef struct packed {
      pix_type                  d;
      pix_type                  td;
      pix_type                  diff;
      logic signed [INT_W-1:0]  interp;
      pix_type                  xp;
      logic                     use_external;
      logic                     row_end;
   } s2_type;

   function automatic pix_type absd(input pix_type a, input pix_type b);
      return (a >= b) ? pix_type'(a - b) : pix_type'(b - a);
   endfunction

   function automatic sdiff_type smax(input sdiff_type a, input sdiff_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic sdiff_type smin(input sdiff_type a, input sdiff_type b);
      return (a < b) ? a : b;
   endfunction

   // Stage valids: 0 input register, 1 products, 2 sums, 3 result register.
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] free;

   req_payload_type s0_ff;
   s1_type          s1_ff;
   s1_type          s1_in;
   s2_type          s2_ff;
   s2_type          s2_in;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;

   // A stage can take new data when it is empty or its content moves on.
   always_comb begin
      free[3] = !v_ff[3] || rsp_chan.ready;
      free[2] = !v_ff[2] || free[3];
      free[1] = !v_ff[1] || free[2];
      free[0] = !v_ff[0] || free[1];
      v_in[0] = free[0] ? req_chan.valid : 1'b1;
      v_in[1] = free[1] ? v_ff[0] : 1'b1;
      v_in[2] = free[2] ? v_ff[1] : 1'b1;
      v_in[3] = free[3] ? v_ff[2] : 1'b1;
   end

   assign req_chan.ready   = free[0];
   assign rsp_chan.valid   = v_ff[3];
   assign rsp_chan.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------- stage 1: neighbour terms and products ----------------
   pix_type p2, n2, p2a4, p2a2, p2b2, p2b4, n2a4, n2a2, n2b2, n2b4;
   pix_type pa, pb, na, nb, ca3, c, e, cb3;
   logic [PIX_W:0]   sum_pn, sum_t1, sum_t2, sum_a2, sum_b2, sum_ce, sum_far;
   logic [PIX_W+1:0] sum_two, sum_four;
   pix_type          avg_a2, avg_b2;

   always_comb begin
      p2   = s0_ff.prev2_center[PIX_W-1:0];
      n2   = s0_ff.next2_center[PIX_W-1:0];
      p2a4 = s0_ff.prev2_ring[0*LANE_W +: PIX_W];
      p2a2 = s0_ff.prev2_ring[1*LANE_W +: PIX_W];
      p2b2 = s0_ff.prev2_ring[2*LANE_W +: PIX_W];
      p2b4 = s0_ff.prev2_ring[3*LANE_W +: PIX_W];
      n2a4 = s0_ff.next2_ring[0*LANE_W +: PIX_W];
      n2a2 = s0_ff.next2_ring[1*LANE_W +: PIX_W];
      n2b2 = s0_ff.next2_ring[2*LANE_W +: PIX_W];
      n2b4 = s0_ff.next2_ring[3*LANE_W +: PIX_W];
      pa   = s0_ff.prev_rows[0*LANE_W +: PIX_W];
      pb   = s0_ff.prev_rows[1*LANE_W +: PIX_W];
      na   = s0_ff.next_rows[0*LANE_W +: PIX_W];
      nb   = s0_ff.next_rows[1*LANE_W +: PIX_W];
      ca3  = s0_ff.cur_rows[0*LANE_W +: PIX_W];
      c    = s0_ff.cur_rows[1*LANE_W +: PIX_W];
      e    = s0_ff.cur_rows[2*LANE_W +: PIX_W];
      cb3  = s0_ff.cur_rows[3*LANE_W +: PIX_W];

      sum_pn   = {1'b0, p2} + {1'b0, n2};
      sum_t1   = {1'b0, absd(pa, c)} + {1'b0, absd(pb, e)};
      sum_t2   = {1'b0, absd(na, c)} + {1'b0, absd(nb, e)};
      sum_a2   = {1'b0, p2a2} + {1'b0, n2a2};
      sum_b2   = {1'b0, p2b2} + {1'b0, n2b2};
      sum_ce   = {1'b0, c} + {1'b0, e};
      sum_far  = {1'b0, ca3} + {1'b0, cb3};
      sum_two  = {1'b0, sum_a2} + {1'b0, sum_b2};
      sum_four = {2'b00, p2a4} + {2'b00, n2a4} + {2'b00, p2b4} + {2'b00, n2b4};
      avg_a2   = sum_a2[PIX_W:1];
      avg_b2   = sum_b2[PIX_W:1];

      s1_in.d      = sum_pn[PIX_W:1];
      s1_in.td0    = absd(p2, n2);
      s1_in.td1    = sum_t1[PIX_W:1];
      s1_in.td2    = sum_t2[PIX_W:1];
      s1_in.b      = $signed({2'b00, avg_a2}) - $signed({2'b00, c});
      s1_in.f      = $signed({2'b00, avg_b2}) - $signed({2'b00, e});
      s1_in.dme    = $signed({2'b00, sum_pn[PIX_W:1]}) - $signed({2'b00, e});
      s1_in.dmc    = $signed({2'b00, sum_pn[PIX_W:1]}) - $signed({2'b00, c});
      s1_in.ce_avg = sum_ce[PIX_W:1];
      s1_in.xp     = s0_ff.external_pixel[PIX_W-1:0];
      s1_in.sel_hf = absd(c, e) > absd(p2, n2);

      s1_in.edge_mode     = s0_ff.edge_mode;
      s1_in.spatial_check = s0_ff.spatial_check;
      s1_in.use_external  = s0_ff.use_external;
      s1_in.row_end       = s0_ff.row_end_in;

      s1_in.m_center = PROD_W'(coef.hf_center) * PROD_W'(sum_pn);
      s1_in.m_two    = PROD_W'(coef.hf_two)    * PROD_W'(sum_two);
      s1_in.m_four   = PROD_W'(coef.hf_four)   * PROD_W'(sum_four);
      s1_in.m_lnear  = PROD_W'(coef.lf_near)   * PROD_W'(sum_ce);
      s1_in.m_lfar   = PROD_W'(coef.lf_far)    * PROD_W'(sum_far);
      s1_in.m_snear  = PROD_W'(coef.sp_near)   * PROD_W'(sum_ce);
      s1_in.m_sfar   = PROD_W'(coef.sp_far)    * PROD_W'(sum_far);
   end

   // ---------------- stage 2: difference limit and blends ----------------
   pix_type                 td_half;
   pix_type                 td_max;
   sdiff_type               hi, lo, wide;
   logic signed [ACC_W-1:0] hf, hf_q, acc, sp;

   always_comb begin
      td_half = s1_ff.td0 >> 1;
      td_max  = (td_half > s1_ff.td1) ? td_half : s1_ff.td1;
      td_max  = (td_max > s1_ff.td2) ? td_max : s1_ff.td2;

      hi   = smax(smax(s1_ff.dme, s1_ff.dmc), smin(s1_ff.b, s1_ff.f));
      lo   = smin(smin(s1_ff.dme, s1_ff.dmc), smax(s1_ff.b, s1_ff.f));
      wide = smax(smax($signed({2'b00, td_max}), lo), -hi);

      // Arithmetic shifts give the floor of the scaled sums.
      hf   = $signed(ACC_W'(s1_ff.m_center)) - $signed(ACC_W'(s1_ff.m_two))
           + $signed(ACC_W'(s1_ff.m_four));
      hf_q = hf >>> HF_SHIFT;
      acc  = hf_q + $signed(ACC_W'(s1_ff.m_lnear)) - $signed(ACC_W'(s1_ff.m_lfar));
      sp   = $signed(ACC_W'(s1_ff.m_snear)) - $signed(ACC_W'(s1_ff.m_sfar));

      s2_in.d  = s1_ff.d;
      s2_in.td = td_max;
      // The widened difference never goes negative and stays below 2^PIX_W.
      s2_in.diff = (!s1_ff.edge_mode || s1_ff.spatial_check) ? wide[PIX_W-1:0] : td_max;
      if (s1_ff.edge_mode) begin
         s2_in.interp = $signed(INT_W'(s1_ff.ce_avg));
      end else if (s1_ff.sel_hf) begin
         s2_in.interp = $signed(acc[ACC_W-1:COEF_SHIFT]);
      end else begin
         s2_in.interp = $signed(sp[ACC_W-1:COEF_SHIFT]);
      end
      s2_in.xp           = s1_ff.xp;
      s2_in.use_external = s1_ff.use_external;
      s2_in.row_end      = s1_ff.row_end;
   end

   // ---------------- stage 3: limit and clamp ----------------
   logic signed [INT_W-1:0] vsel, lo_b, hi_b, v1, v2, v3;
   pix_type                 lim;
   pix_type                 pixel;

   always_comb begin
      lim  = (coef.peak > PEAK_W'(PIX_MAX)) ? PIX_MAX : coef.peak[PIX_W-1:0];
      vsel = s2_ff.use_external ? $signed(INT_W'(s2_ff.xp)) : s2_ff.interp;
      lo_b = $signed(INT_W'(s2_ff.d)) - $signed(INT_W'(s2_ff.diff));
      hi_b = $signed(INT_W'(s2_ff.d)) + $signed(INT_W'(s2_ff.diff));
      v1   = (vsel < lo_b) ? lo_b : vsel;
      v2   = (v1 > hi_b) ? hi_b : v1;
      v3   = (s2_ff.td == '0) ? $signed(INT_W'(s2_ff.d)) : v2;
      if (v3 < 0) begin
         pixel = '0;
      end else if (v3 > $signed(INT_W'(lim))) begin
         pixel = lim;
      end else begin
         pixel = v3[PIX_W-1:0];
      end
      out_in.out_pixel   = LANE_W'(pixel);
      out_in.row_end_out = s2_ff.row_end;
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         s0_ff <= req_chan.payload;
      end
      if (free[1]) begin
         s1_ff <= s1_in;
      end
      if (free[2]) begin
         s2_ff <= s2_in;
      end
      if (free[3]) begin
         out_ff <= out_in;
      end
   end

   `MADP_ASSERT_NEXT(a_s0_advances, clock, reset, v_ff[0] && free[1], v_ff[1], "stage 0 request lost on advance")
   `MADP_ASSERT_IMPL(a_stall_only_full, clock, reset, !free[0], &v_ff, "request stalled with a bubble in the pipeline")
   `MADP_ASSERT_NEXT(a_s1_holds, clock, reset, v_ff[1] && !free[2], v_ff[1] && $stable(s1_ff), "stage 1 changed while blocked")

endmodule

// File: hw/rtl/motion_adaptive_deinterlace_pixel.sv
`timescale 1ns / 1ps
// Motion-adaptive deinterlacer, one missing-line pixel per request.
// req_chan carries the vertical neighbours from five fields plus mode bits;
// rsp_chan returns the interpolated pixel and the row-end marker, one
// response per request, in order. csr_chan writes the blend weights and the
// peak value by register index; it is always ready, and writes to indexes
// past the register list are ignored. Registers should only change while
// no request is in flight.
// Pipeline: a request accepted on req_chan passes the input register,
// product stage, sum stage and result register before it is presented
// on rsp_chan. Throughput is one request per cycle while rsp_chan is not
// stalled; the product stage with its seven parallel coefficient
// multipliers sets the cycle. When the receiver stalls, the four stages
// fill up and back-pressure req_chan only once every stage holds a
// request; a bubble anywhere keeps req_chan ready.
// Reset empties the pipeline and loads every register with its default.

module motion_adaptive_deinterlace_pixel import madp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   madp_req_if.sink     req_chan,
   madp_rsp_if.source   rsp_chan,
   madp_csr_if.sink     csr_chan
);

   coef_type coef;

   madp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .coef     (coef)
   );

   madp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .coef     (coef),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/motion_adaptive_deinterlace_pixel_tb.sv
`timescale 1ns / 1ps

module motion_adaptive_deinterlace_pixel_tb import madp_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 215;
   localparam int HOLD_CYCLES = 80;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_INDEX = 4'd12;

   typedef enum int {MIX_NOISE, MIX_SMOOTH, MIX_STILL, MIX_EXTREME} pixel_mix_type;

   class deinterlace_scoreboard;
      coef_type        coef;
      rsp_payload_type expected_pixels[$];
      int              errors;
      int              checked;

      function new();
         coef.lf_near   = RST_LF_NEAR;
         coef.lf_far    = RST_LF_FAR;
         coef.hf_center = RST_HF_CENTER;
         coef.hf_two    = RST_HF_TWO;
         coef.hf_four   = RST_HF_FOUR;
         coef.sp_near   = RST_SP_NEAR;
         coef.sp_far    = RST_SP_FAR;
         coef.peak      = RST_PEAK;
         errors  = 0;
         checked = 0;
      endfunction

      function longint mag(longint a);
         return (a < 0) ? -a : a;
      endfunction

      function longint larger(longint a, longint b);
         return (a > b) ? a : b;
      endfunction

      function longint smaller(longint a, longint b);
         return (a < b) ? a : b;
      endfunction

      function longint lane(logic [63:0] word, int idx);
         return longint'(word[LANE_W*idx +: LANE_W]);
      endfunction

      function void apply_register_write(logic [CSR_IDX_W-1:0] index,
                                         logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_LF_NEAR:   coef.lf_near   = data[COEF_W-1:0];
            REG_LF_FAR:    coef.lf_far    = data[COEF_W-1:0];
            REG_HF_CENTER: coef.hf_center = data[COEF_W-1:0];
            REG_HF_TWO:    coef.hf_two    = data[COEF_W-1:0];
            REG_HF_FOUR:   coef.hf_four   = data[COEF_W-1:0];
            REG_SP_NEAR:   coef.sp_near   = data[COEF_W-1:0];
            REG_SP_FAR:    coef.sp_far    = data[COEF_W-1:0];
            REG_PEAK:      coef.peak      = data[PEAK_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_payload_type predict_pixel(req_payload_type r);
         longint p2, n2, p2a4, p2a2, p2b2, p2b4, n2a4, n2a2, n2b2, n2b4;
         longint pa, pb, na, nb, ca3, c, e, cb3;
         longint d, td0, td1, td2, td, diff, b, f, hi, lo, hf, acc, interp, v, lim;
         rsp_payload_type res;
         p2   = r.prev2_center;
         n2   = r.next2_center;
         p2a4 = lane(r.prev2_ring, 0);
         p2a2 = lane(r.prev2_ring, 1);
         p2b2 = lane(r.prev2_ring, 2);
         p2b4 = lane(r.prev2_ring, 3);
         n2a4 = lane(r.next2_ring, 0);
         n2a2 = lane(r.next2_ring, 1);
         n2b2 = lane(r.next2_ring, 2);
         n2b4 = lane(r.next2_ring, 3);
         pa   = lane(64'(r.prev_rows), 0);
         pb   = lane(64'(r.prev_rows), 1);
         na   = lane(64'(r.next_rows), 0);
         nb   = lane(64'(r.next_rows), 1);
         ca3  = lane(r.cur_rows, 0);
         c    = lane(r.cur_rows, 1);
         e    = lane(r.cur_rows, 2);
         cb3  = lane(r.cur_rows, 3);

         d   = (p2 + n2) >>> 1;
         td0 = mag(p2 - n2);
         td1 = (mag(pa - c) + mag(pb - e)) >>> 1;
         td2 = (mag(na - c) + mag(nb - e)) >>> 1;
         td  = larger(larger(td0 >>> 1, td1), td2);
         diff = td;

         // Spatial widening: always on inner lines, on request on edge lines.
         if (!r.edge_mode || r.spatial_check) begin
            b  = ((p2a2 + n2a2) >>> 1) - c;
            f  = ((p2b2 + n2b2) >>> 1) - e;
            hi = larger(larger(d - e, d - c), smaller(b, f));
            lo = smaller(smaller(d - e, d - c), larger(b, f));
            diff = larger(larger(td, lo), -hi);
         end

         if (r.edge_mode) begin
            interp = (c + e) >>> 1;
         end else if (mag(c - e) > td0) begin
            hf = longint'(coef.hf_center) * (p2 + n2)
               - longint'(coef.hf_two) * (p2a2 + n2a2 + p2b2 + n2b2)
               + longint'(coef.hf_four) * (p2a4 + n2a4 + p2b4 + n2b4);
            acc = (hf >>> HF_SHIFT)
                + longint'(coef.lf_near) * (c + e)
                - longint'(coef.lf_far) * (ca3 + cb3);
            interp = acc >>> COEF_SHIFT;
         end else begin
            acc = longint'(coef.sp_near) * (c + e) - longint'(coef.sp_far) * (ca3 + cb3);
            interp = acc >>> COEF_SHIFT;
         end

         if (r.use_external) begin
            interp = r.external_pixel;
         end
         v = smaller(larger(interp, d - diff), d + diff);
         if (td == 0) begin
            v = d;
         end
         lim = smaller(longint'(coef.peak), longint'(PIX_MAX));
         if (v < 0) begin
            v = 0;
         end
         if (v > lim) begin
            v = lim;
         end
         res.out_pixel   = v[15:0];
         res.row_end_out = r.row_end_in;
         return res;
      endfunction

      function void note_request(req_payload_type r);
         expected_pixels.push_back(predict_pixel(r));
      endfunction

      task report_mismatch(string what);
         if (errors < 100) begin
            $display("mismatch at response %0d: %s", checked, what);
         end
         errors++;
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_pixels.pop_front();
            if (got.out_pixel !== want.out_pixel) begin
               report_mismatch($sformatf("out_pixel %h, predicted %h",
                                         got.out_pixel, want.out_pixel));
            end
            if (got.row_end_out !== want.row_end_out) begin
               report_mismatch($sformatf("row_end_out %b, predicted %b",
                                         got.row_end_out, want.row_end_out));
            end
         end
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic recv_hold;
   logic hold_arm = 1'b0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   cycle_count = 0;

   deinterlace_scoreboard sb;

   madp_req_if req_if ();
   madp_rsp_if rsp_if ();
   madp_csr_if csr_if ();

   motion_adaptive_deinterlace_pixel i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("motion_adaptive_deinterlace_pixel regression: fail");
         $finish;
      end
   end

   // Response side: check what was accepted at this edge, then pick ready.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_response(rsp_if.payload);
      end
      rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // One long stall of the response side so the pipeline fills and
   // pushes back on the request side.
   initial begin : rsp_hold_off
      int held;
      recv_hold = 1'b0;
      @(posedge hold_arm);
      @(posedge clock);
      recv_hold <= 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) begin
         @(posedge clock);
      end
      recv_hold <= 1'b0;
   end

   function automatic logic [15:0] near_pixel(int base, int spread);
      int v;
      v = base + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      return 16'(v);
   endfunction

   function automatic logic [15:0] pick_pixel(pixel_mix_type mix, int base, int spread);
      if (mix == MIX_NOISE) begin
         return 16'($urandom);
      end else if (mix == MIX_EXTREME) begin
         case ($urandom_range(2))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
         endcase
      end
      return near_pixel(base, spread);
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      pixel_mix_type   mix;
      int              base, spread, roll;
      roll = $urandom_range(9);
      if (roll < 2) begin
         mix = MIX_NOISE;
      end else if (roll < 6) begin
         mix = MIX_SMOOTH;
      end else if (roll < 8) begin
         mix = MIX_STILL;
      end else begin
         mix = MIX_EXTREME;
      end
      base = $urandom_range(65535);
      case ($urandom_range(4))
         0: spread = 0;
         1: spread = 2;
         2: spread = 16;
         3: spread = 256;
         default: spread = 4096;
      endcase
      r.edge_mode      = 1'($urandom_range(1));
      r.spatial_check  = 1'($urandom_range(1));
      r.use_external   = 1'($urandom_range(1));
      r.row_end_in     = 1'($urandom_range(1));
      r.prev2_center   = pick_pixel(mix, base, spread);
      r.next2_center   = pick_pixel(mix, base, spread);
      r.prev2_ring     = {pick_pixel(mix, base, spread), pick_pixel(mix, base, spread),
                          pick_pixel(mix, base, spread), pick_pixel(mix, base, spread)};
      r.next2_ring     = {pick_pixel(mix, base, spread), pick_pixel(mix, base, spread),
                          pick_pixel(mix, base, spread), pick_pixel(mix, base, spread)};
      r.prev_rows      = {pick_pixel(mix, base, spread), pick_pixel(mix, base, spread)};
      r.next_rows      = {pick_pixel(mix, base, spread), pick_pixel(mix, base, spread)};
      r.cur_rows       = {pick_pixel(mix, base, spread), pick_pixel(mix, base, spread),
                          pick_pixel(mix, base, spread), pick_pixel(mix, base, spread)};
      r.external_pixel = pick_pixel(mix, base, spread);
      // A still pixel: no temporal change at all, so the result is the average, limited to the peak.
      if (mix == MIX_STILL) begin
         r.next2_center = r.prev2_center;
         r.prev_rows    = {r.cur_rows[47:32], r.cur_rows[31:16]};
         r.next_rows    = r.prev_rows;
      end
      return r;
   endfunction

   function automatic coef_type phase_setting(int phase);
      coef_type k;
      case (phase)
         1: begin
            k = '{default: 14'h3FFF, peak: 16'hFFFF};
         end
         2: begin
            k = '{default: 14'h0000, peak: 16'd255};
         end
         3, 4: begin
            k.lf_near   = 14'($urandom_range(16383));
            k.lf_far    = 14'($urandom_range(16383));
            k.hf_center = 14'($urandom_range(16383));
            k.hf_two    = 14'($urandom_range(16383));
            k.hf_four   = 14'($urandom_range(16383));
            k.sp_near   = 14'($urandom_range(16383));
            k.sp_far    = 14'($urandom_range(16383));
            k.peak      = (phase == 3) ? 16'($urandom_range(65535, 255)) : 16'd1023;
         end
         default: begin
            k.lf_near   = RST_LF_NEAR;
            k.lf_far    = RST_LF_FAR;
            k.hf_center = RST_HF_CENTER;
            k.hf_two    = RST_HF_TWO;
            k.hf_four   = RST_HF_FOUR;
            k.sp_near   = RST_SP_NEAR;
            k.sp_far    = RST_SP_FAR;
            k.peak      = RST_PEAK;
         end
      endcase
      return k;
   endfunction

   task automatic send_request(req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(item);
   endtask

   task automatic stop_requests();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.expected_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= {index, data};
      do @(posedge clock); while (!csr_if.ready);
      sb.apply_register_write(index, data);
   endtask

   task automatic program_registers(coef_type k);
      csr_write(REG_LF_NEAR,   16'(k.lf_near));
      csr_write(REG_LF_FAR,    16'(k.lf_far));
      csr_write(REG_HF_CENTER, 16'(k.hf_center));
      csr_write(REG_HF_TWO,    16'(k.hf_two));
      csr_write(REG_HF_FOUR,   16'(k.hf_four));
      csr_write(REG_SP_NEAR,   16'(k.sp_near));
      csr_write(REG_SP_FAR,    16'(k.sp_far));
      csr_write(REG_PEAK,      k.peak);
      // A write past the register list must leave every register alone.
      csr_write(UNMAPPED_INDEX, 16'($urandom));
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      req_payload_type item;
      int              phase, n;
      sb = new();
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 83;

      // Directed requests under the reset weights.
      item = '0;
      send_request(item);
      item = '1;
      send_request(item);
      item.edge_mode = 1'b0;
      item.use_external = 1'b0;
      item.row_end_in = 1'b0;
      send_request(item);

      // Edge line, with and without the spatial widening.
      item = '0;
      item.edge_mode    = 1'b1;
      item.prev2_center = 16'd100;
      item.next2_center = 16'd50000;
      item.prev2_ring   = 64'h1234_8000_0200_FFFF;
      item.next2_ring   = 64'hFFFF_0100_9000_0000;
      item.prev_rows    = {16'd2000, 16'd900};
      item.next_rows    = {16'd40000, 16'd30};
      item.cur_rows     = {16'd65535, 16'd3000, 16'd1000, 16'd0};
      send_request(item);
      item.spatial_check = 1'b1;
      item.row_end_in    = 1'b1;
      send_request(item);

      // Inner line, large vertical step: high/low-frequency blend.
      item = '0;
      item.prev2_center = 16'd32768;
      item.next2_center = 16'd32768;
      item.prev2_ring   = 64'hFFFF_0000_FFFF_0000;
      item.next2_ring   = 64'h0000_FFFF_0000_FFFF;
      item.prev_rows    = {16'hFFFF, 16'h0000};
      item.next_rows    = {16'h8000, 16'h4000};
      item.cur_rows     = {16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
      send_request(item);

      // Inner line, strong motion: spatial cubic, once driven below zero.
      item.prev2_center = 16'd0;
      item.next2_center = 16'd65535;
      item.cur_rows     = {16'd65535, 16'd40000, 16'd40000, 16'd65535};
      send_request(item);
      item.cur_rows     = {16'd65535, 16'd0, 16'd0, 16'd65535};
      send_request(item);

      // No temporal change: the average comes out whatever the mode.
      item = '0;
      item.prev2_center = 16'd1234;
      item.next2_center = 16'd1234;
      item.prev2_ring   = 64'h0000_FFFF_0000_FFFF;
      item.cur_rows     = {16'd9, 16'd700, 16'd500, 16'd60000};
      item.prev_rows    = {16'd700, 16'd500};
      item.next_rows    = {16'd700, 16'd500};
      item.use_external = 1'b1;
      item.external_pixel = 16'hFFFF;
      send_request(item);

      // External pixel at both extremes, limited by the temporal difference or its spatial widening.
      item.next2_center = 16'd5000;
      send_request(item);
      item.external_pixel = 16'h0000;
      item.edge_mode      = 1'b1;
      send_request(item);

      for (phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            program_registers(phase_setting(phase));
         end
         if (phase < 2) begin
            send_idle_pct = 12;
            recv_idle_pct = 83;
         end else if (phase < 4) begin
            send_idle_pct = 83;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 4) begin
            hold_arm <= 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == 100) begin
               stop_requests();
               wait_drained();
            end
            send_request(random_request());
         end
         stop_requests();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (sb.expected_pixels.size() != 0) begin
         sb.report_mismatch($sformatf("%0d predicted responses never arrived",
                                      sb.expected_pixels.size()));
      end
      if (sb.errors == 0) begin
         $display("motion_adaptive_deinterlace_pixel regression: pass");
      end else begin
         $display("motion_adaptive_deinterlace_pixel regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/madp_pkg.sv
hw/rtl/madp_if.sv
hw/rtl/madp_csr.sv
hw/rtl/madp_core.sv
hw/rtl/motion_adaptive_deinterlace_pixel.sv
dv/motion_adaptive_deinterlace_pixel_tb.sv
